// ----- rtl/isi_pkg.sv -----
package isi_pkg;
    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int FracBits  = 16;
    localparam int XW = $clog2(MaxWidth);
    localparam int YW = $clog2(MaxHeight);
    localparam int AW = XW + YW;
    localparam int SW = $clog2(MaxWidth) + 1;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_SW   = 3'd1;
    localparam logic [2:0] REG_SH   = 3'd2;
    localparam logic [2:0] REG_DW   = 3'd3;
    localparam logic [2:0] REG_DH   = 3'd4;

    localparam logic [1:0] MODE_INDEXED = 2'd0;
    localparam logic [1:0] MODE_RGB     = 2'd1;
    localparam logic [1:0] MODE_RGBA    = 2'd2;

    typedef struct packed {
        logic              go;
        logic [2*SW-1:0]   num;
        logic [SW-1:0]     den;
    } div_req_t;

    function automatic logic [SW-1:0] clamp_size(input logic [8:0] v, input int maxv);
        logic [SW-1:0] r;
        begin
            if (v == 9'd0)
                r = SW'(1);
            else if (32'(v) > maxv)
                r = SW'(maxv);
            else
                r = SW'(v);
            return r;
        end
    endfunction
endpackage

// ----- rtl/isi_div.sv -----
// Restoring divider: quotient and Q0.FracBits fraction of num/den, one bit per cycle.
module isi_div (
    input  logic                clk,
    input  logic                rst_n,
    input  isi_pkg::div_req_t   req,
    output logic                done,
    output logic [isi_pkg::SW-1:0]      quot,
    output logic [isi_pkg::FracBits-1:0] frac
);
    import isi_pkg::*;
    localparam int QW = 2 * SW + FracBits;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] q_reg, q_next;
    logic [SW-1:0] r_reg, r_next;
    logic [SW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [SW+1:0] trial;
    logic [SW:0]   shifted;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        shifted = {r_reg, q_reg[QW-1]};
        trial = {1'b0, shifted} - {2'b0, d_reg};
        done = 1'b0;
        if (req.go)
        begin
            q_next = {req.num, {FracBits{1'b0}}};
            r_next = '0;
            d_next = req.den;
            cnt_next = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[SW+1])
            begin
                r_next = trial[SW-1:0];
                q_next = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[SW-1:0];
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    assign quot = q_next[FracBits +: SW];
    assign frac = q_next[FracBits-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule

// ----- rtl/image_scaler_interpolating.sv -----
// Interpolating image scaler.
// Input channel (in_valid/in_stall): req_type 0 writes pixel_in to the source
// store at (coord_x, coord_y); loads outside the source size are dropped and
// give no result. req_type 1 queries one destination pixel and gives exactly
// one transaction on the output channel (out_valid/out_stall).
// Loads are taken one per cycle, back to back, while no query is in progress.
// A query divides each coordinate times the source size by the destination
// size in a shared bit-serial divider, then reads up to four neighbours from
// the single-port store (one per cycle, data registered), then blends channel
// by channel, a multiply step then a sum step per channel; indexed mode reads
// only the base pixel and returns its low byte without blending.
// Queries outside the destination return 0 with range_error set in the cycle
// after acceptance. The next transaction is taken in the cycle after the
// result leaves.
// The result sits in an output register; the block holds it while out_stall
// is high and takes no new transaction until it has gone.
// Reset returns the registers to four-channel mode and 256x256 sizes; the
// store itself is not cleared and must be loaded before it is queried.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken whenever
// cfg_we is high, and must only be issued while the block is idle.
module image_scaler_interpolating (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  coord_x,
    input  logic [7:0]  coord_y,
    input  logic [31:0] pixel_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pixel_out,
    output logic        range_error
);
    import isi_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIVX = 4'd1;
    localparam logic [3:0] ST_DIVY = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_SUM  = 4'd5;
    localparam logic [3:0] ST_OUT  = 4'd6;
    localparam logic [3:0] ST_STX  = 4'd7;
    localparam logic [3:0] ST_STY  = 4'd8;

    // configuration
    logic [1:0] mode_reg;
    logic [8:0] sw_cfg_reg, sh_cfg_reg, dw_cfg_reg, dh_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RGBA;
            sw_cfg_reg <= 9'd256;
            sh_cfg_reg <= 9'd256;
            dw_cfg_reg <= 9'd256;
            dh_cfg_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE: mode_reg   <= cfg_data[1:0];
                REG_SW:   sw_cfg_reg <= cfg_data;
                REG_SH:   sh_cfg_reg <= cfg_data;
                REG_DW:   dw_cfg_reg <= cfg_data;
                REG_DH:   dh_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [SW-1:0] sw_c, sh_c, dw_c, dh_c;
    assign sw_c = clamp_size(sw_cfg_reg, MaxWidth);
    assign sh_c = clamp_size(sh_cfg_reg, MaxHeight);
    assign dw_c = clamp_size(dw_cfg_reg, MaxWidth);
    assign dh_c = clamp_size(dh_cfg_reg, MaxHeight);

    // source store, single port, registered read
    logic [31:0] store_mem [0:(1 << AW)-1];
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_q_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= pixel_in;
        mem_q_reg <= store_mem[mem_addr];
    end

    // control
    logic [3:0] st_reg, st_next;
    logic [7:0] qx_reg, qy_reg;
    logic [XW-1:0] ix_reg;
    logic [YW-1:0] iy_reg;
    logic [FracBits-1:0] fx_reg, fy_reg;
    logic [2:0] rd_reg;
    logic [31:0] p_reg [0:3];
    logic [1:0]  ch_reg;
    logic [FracBits+9:0] prod_reg [0:3];
    logic [31:0] res_reg;
    logic        rerr_reg;
    logic        ovalid_reg;
    // use-base flag, registered like the store's read data
    logic        rdb_reg;

    div_req_t dreq;
    logic dv_done;
    logic [SW-1:0] dv_quot;
    logic [FracBits-1:0] dv_frac;

    isi_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .done (dv_done),
        .quot (dv_quot),
        .frac (dv_frac)
    );

    logic in_acc;
    assign in_stall = (st_reg != ST_IDLE);
    assign in_acc = in_valid && !in_stall;

    logic load_ok;
    assign load_ok = (SW'(coord_x) < sw_c) && (SW'(coord_y) < sh_c);

    logic [2*SW-1:0] load_addr;
    assign load_addr = (2*SW)'(coord_y) * (2*SW)'(sw_c) + (2*SW)'(coord_x);

    // neighbour selection
    logic last_row, last_col;
    assign last_row = (SW'(iy_reg) == sh_c - SW'(1));
    assign last_col = (SW'(ix_reg) == sw_c - SW'(1));

    logic [XW-1:0] rx;
    logic [YW-1:0] ry;
    logic use_base;
    always_comb
    begin
        rx = ix_reg;
        ry = iy_reg;
        use_base = 1'b0;
        unique case (rd_reg[1:0])
            2'd0: ;
            2'd1:
            begin
                ry = iy_reg + YW'(1);
                use_base = last_row;
            end
            2'd2:
            begin
                rx = ix_reg + XW'(1);
                use_base = last_col;
            end
            default:
            begin
                rx = ix_reg + XW'(1);
                ry = iy_reg + YW'(1);
                use_base = last_row || last_col;
            end
        endcase
    end

    logic [2*SW-1:0] lin_full;
    assign lin_full = (2*SW)'(ry) * (2*SW)'(sw_c) + (2*SW)'(rx);

    // divider numerators: c*s < 2^16, held in 2*SW bits
    logic [2*SW-1:0] numx, numy;
    assign numx = (2*SW)'(qx_reg) * (2*SW)'(sw_c);
    assign numy = (2*SW)'(qy_reg) * (2*SW)'(sh_c);

    // weights
    logic [FracBits:0]   fz;
    logic [FracBits+2:0] w1;
    assign fz = ({1'b0, fx_reg} + {1'b0, fy_reg}) >> 1;
    assign w1 = (FracBits+3)'(3) << FracBits;

    logic [7:0] c1, c2, c3, c4;
    assign c1 = p_reg[0][8*ch_reg +: 8];
    assign c2 = p_reg[1][8*ch_reg +: 8];
    assign c3 = p_reg[2][8*ch_reg +: 8];
    assign c4 = p_reg[3][8*ch_reg +: 8];

    logic [FracBits+2:0] wb;
    assign wb = w1 - (FracBits+3)'(fx_reg) - (FracBits+3)'(fy_reg) - (FracBits+3)'(fz);

    logic [FracBits+11:0] ssum;
    logic [FracBits+13:0] num2;
    logic [7:0] cval;
    localparam logic [FracBits+13:0] ThreeOne = (FracBits+14)'(3) << FracBits;
    always_comb
    begin
        ssum = (FracBits+12)'(prod_reg[0]) + (FracBits+12)'(prod_reg[1])
             + (FracBits+12)'(prod_reg[2]) + (FracBits+12)'(prod_reg[3]);
        num2 = ({1'b0, ssum, 1'b0}) + ThreeOne;
        // divide by 6*ONE: shift by FracBits+1, then by 3 (value < 2^10)
        cval = 8'((num2 >> (FracBits + 1)) * 11'd683 >> 11);
    end

    logic [1:0] nch_last;
    assign nch_last = (mode_reg == MODE_RGB) ? 2'd2 : 2'd3;

    always_comb
    begin
        st_next = st_reg;
        mem_we = 1'b0;
        mem_addr = AW'(lin_full);
        dreq = '0;
        if (st_reg == ST_IDLE && in_acc)
        begin
            if (!req_type)
            begin
                mem_addr = AW'(load_addr);
                mem_we = load_ok;
            end
            else if (SW'(coord_x) >= dw_c || SW'(coord_y) >= dh_c)
                st_next = ST_OUT;
            else
                st_next = ST_STX;
        end
        unique case (st_reg)
            ST_STX:
            begin
                dreq.go = 1'b1;
                dreq.num = numx;
                dreq.den = dw_c;
                st_next = ST_DIVX;
            end
            ST_DIVX:
                if (dv_done)
                    st_next = ST_STY;
            ST_STY:
            begin
                dreq.go = 1'b1;
                dreq.num = numy;
                dreq.den = dh_c;
                st_next = ST_DIVY;
            end
            ST_DIVY:
                if (dv_done)
                    st_next = ST_RD;
            ST_RD:
                if (rd_reg == 3'd4 || (mode_reg == MODE_INDEXED && rd_reg == 3'd1))
                    st_next = (mode_reg == MODE_INDEXED) ? ST_OUT : ST_MUL;
            ST_MUL:
                st_next = ST_SUM;
            ST_SUM:
                st_next = (ch_reg == nch_last) ? ST_OUT : ST_MUL;
            ST_OUT:
                if (!out_stall)
                    st_next = ST_IDLE;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ovalid_reg <= (st_next == ST_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && in_acc)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
            rd_reg <= '0;
            ch_reg <= '0;
            res_reg <= '0;
            rerr_reg <= req_type;
        end
        if (st_reg == ST_DIVX && dv_done)
        begin
            ix_reg <= XW'(dv_quot);
            fx_reg <= dv_frac;
        end
        if (st_reg == ST_DIVY && dv_done)
        begin
            iy_reg <= YW'(dv_quot);
            fy_reg <= dv_frac;
            rerr_reg <= 1'b0;
        end
        if (st_reg == ST_RD)
        begin
            rd_reg <= rd_reg + 3'd1;
            // missing neighbour at the last row or column takes the base pixel
            if (rd_reg != 3'd0)
                p_reg[rd_reg[1:0] - 2'd1] <= (rd_reg != 3'd1 && rdb_reg) ? p_reg[0]
                                                                          : mem_q_reg;
            if (rd_reg == 3'd1 && mode_reg == MODE_INDEXED)
                res_reg <= {24'd0, mem_q_reg[7:0]};
        end
        if (st_reg == ST_MUL)
        begin
            prod_reg[0] <= (FracBits+10)'(c1) * (FracBits+10)'(wb);
            prod_reg[1] <= (FracBits+10)'(c2) * (FracBits+10)'(fy_reg);
            prod_reg[2] <= (FracBits+10)'(c3) * (FracBits+10)'(fx_reg);
            prod_reg[3] <= (FracBits+10)'(c4) * (FracBits+10)'(fz);
        end
        if (st_reg == ST_SUM)
        begin
            res_reg[8*ch_reg +: 8] <= cval;
            ch_reg <= ch_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        rdb_reg <= use_base;
    end

    assign out_valid = ovalid_reg;
    assign pixel_out = res_reg;
    assign range_error = rerr_reg;
endmodule
